// ----- rtl/mlp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types, codes and arithmetic constants of the perceptron classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mlp_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_FIN,
    S_OUT,
    S_DONE
  } state_t;

  // steps of the hidden-unit finishing pass
  typedef enum logic [2:0] {
    F_RD,
    F_BIAS,
    F_SUM,
    F_MAG,
    F_MUL,
    F_PROD,
    F_DIV
  } fin_step_t;

  localparam logic [1:0] ACT_W1   = 2'd0;
  localparam logic [1:0] ACT_W2   = 2'd1;
  localparam logic [1:0] ACT_PIX  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd2;

  localparam int ACC_W   = 40;
  localparam int WGT_W   = 16;
  localparam int HID_W   = 13;
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [2:0] CLS_NONE   = 3'd4;
  localparam logic [2:0] CLS_LAST   = 3'd4;

  // floor(2^23 / 255): estimate of x/255 low by at most one for x < 2^23
  localparam logic signed [MUL_B_W-1:0] RECIP_255 = 17'sd32896;
  // magnitudes from 255*32769 upward saturate
  localparam logic [ACC_W-1:0] DIV_SAT = 40'd8356095;
  localparam logic [ACC_W-1:0] ROUND_HALF = 40'd127;

  // piecewise-linear sigmoid, q4.12 magnitude in, q1.12 out
  function automatic logic [HID_W-1:0] sigmoid_q12(input logic neg, input logic [15:0] a);
    logic [15:0] y;
    if (a >= 16'd20480) begin
      y = 16'd4096;
    end else if (a >= 16'd9728) begin
      y = (a >> 5) + 16'd3456;
    end else if (a >= 16'd4096) begin
      y = (a >> 3) + 16'd2560;
    end else begin
      y = (a >> 2) + 16'd2048;
    end
    if (neg) begin
      y = 16'd4096 - y;
    end
    return y[HID_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mlp_mul.sv -----
// ----------------------------------------------------------------------------
// mlp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_mul (
  input  wire logic                                clk,
  input  wire logic signed [mlp_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [mlp_pkg::MUL_B_W-1:0] b,
  output logic signed [mlp_pkg::PROD_W-1:0]       p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ----- rtl/mlp_image_classifier_core.sv -----
// ----------------------------------------------------------------------------
// mlp_image_classifier_core
// Two-layer sigmoid perceptron in q4.12 with one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in  | in_tvalid / in_tready  | in_tdata, in_tuser (action), in_tlast
//  out     | out | out_tvalid / out_tready| out_tdata (class, mismatch)
//
// weight words are written as they are taken. a pixel word within the input
// count runs nh hidden units through the shared multiplier at one a cycle.
// the last pixel adds a pass per hidden unit for bias, rescale and sigmoid,
// then up to four output sums, and the result is posted to the output.
// reset is synchronous; weight memories are not cleared. in_tready is low
// while a word is in work; a result waits in the output register.
`default_nettype none

module mlp_image_classifier_core #(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_HIDDEN  = 32,
  parameter int MAX_OUTPUTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // weight_source[10:0], weight_target[16:11], weight_value[32:17], pixel_value[40:33]
  input  wire logic [47:0] in_tdata,
  // action[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // class_index[2:0], count_mismatch[3]
  output logic [7:0]       out_tdata
);

  localparam int W1_STRIDE = MAX_HIDDEN + 1;
  localparam int W2_STRIDE = MAX_OUTPUTS + 1;
  localparam int W1_DEPTH  = (MAX_INPUTS + 1) * W1_STRIDE;
  localparam int W2_DEPTH  = W2_STRIDE * W1_STRIDE;
  localparam int W1AW      = $clog2(W1_DEPTH);
  localparam int W2AW      = $clog2(W2_DEPTH);
  localparam int HCW       = $clog2(MAX_HIDDEN + 2);
  localparam int HIW       = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int UW        = $clog2(MAX_INPUTS + 1);
  localparam int NIW       = ($clog2(MAX_INPUTS + 1) > 11) ? $clog2(MAX_INPUTS + 1) : 11;
  localparam int ACC_W     = mlp_pkg::ACC_W;
  localparam int WGT_W     = mlp_pkg::WGT_W;
  localparam int HID_W     = mlp_pkg::HID_W;

  // payload fields
  logic [10:0]             in_src;
  logic [5:0]              in_tgt;
  logic signed [WGT_W-1:0] in_wgt;
  logic [7:0]              in_pix;

  assign in_src = in_tdata[10:0];
  assign in_tgt = in_tdata[16:11];
  assign in_wgt = $signed(in_tdata[32:17]);
  assign in_pix = in_tdata[40:33];

  // configuration
  logic [10:0] in_cnt_r;
  logic [5:0]  hid_cnt_r;

  assign cfg_ready = 1'b1;

  // output count is not stored; the second table is sized by MAX_OUTPUTS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= 11'd1024;
      hid_cnt_r <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        mlp_pkg::CFG_INPUT_COUNT:  in_cnt_r  <= cfg_data;
        mlp_pkg::CFG_HIDDEN_COUNT: hid_cnt_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic [HCW-1:0] nh;
  logic [NIW-1:0] ni;

  always_comb begin
    if (int'(hid_cnt_r) > MAX_HIDDEN) begin
      nh = HCW'(MAX_HIDDEN);
    end else begin
      nh = HCW'(hid_cnt_r);
    end
    if (int'(in_cnt_r) > MAX_INPUTS) begin
      ni = NIW'(MAX_INPUTS);
    end else begin
      ni = NIW'(in_cnt_r);
    end
  end

  // state
  mlp_pkg::state_t    state_r, state_nxt;
  mlp_pkg::fin_step_t fstep_r, fstep_nxt;
  logic [HCW-1:0]     k_r, k_nxt;
  logic [HCW-1:0]     j_r, j_nxt;
  logic [2:0]         oj_r, oj_nxt;
  logic               v1_r, v1_nxt, v2_r, v2_nxt;
  logic [HCW-1:0]     idx1_r, idx1_nxt, idx2_r, idx2_nxt;
  logic [7:0]         pix_r, pix_nxt;
  logic               last_r, last_nxt;
  logic               mism_r, mism_nxt;
  logic [UW-1:0]      unit_r, unit_nxt;
  logic [10:0]        pos_r, pos_nxt;
  logic signed [24:0] b255_r, b255_nxt;
  logic signed [ACC_W-1:0] sum_r, sum_nxt;
  logic               neg_r, neg_nxt;
  logic               sat_r, sat_nxt;
  logic [22:0]        mag_r, mag_nxt;
  logic [15:0]        q_r, q_nxt;
  logic signed [ACC_W-1:0] o_r, o_nxt;
  logic [2:0]         cls_r, cls_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;

  // storage
  logic signed [WGT_W-1:0] w1_mem [W1_DEPTH];
  logic signed [WGT_W-1:0] w2_mem [W2_DEPTH];
  logic signed [WGT_W-1:0] w1_q_r, w2_q_r;
  logic signed [ACC_W-1:0] acc_r [MAX_HIDDEN];
  logic [HID_W-1:0]        hid_r [MAX_HIDDEN];

  logic [W1AW-1:0] w1_raddr, w1_waddr;
  logic [W2AW-1:0] w2_raddr, w2_waddr;
  logic            w1_we, w2_we;
  logic            acc_we, acc_clr, hid_we;
  logic [HIW-1:0]  acc_widx, hid_widx;
  logic signed [ACC_W-1:0] acc_wdata;
  logic [HID_W-1:0]        hid_wdata;

  logic signed [mlp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mlp_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mlp_pkg::PROD_W-1:0]  mul_p;

  mlp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  logic in_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == mlp_pkg::S_IDLE);

  assign w1_waddr = W1AW'(W1AW'(in_src) * W1AW'(W1_STRIDE) + W1AW'(in_tgt));
  assign w2_waddr = W2AW'(W2AW'(in_src) * W2AW'(W2_STRIDE) + W2AW'(in_tgt));
  assign w1_we    = in_acc && (in_tuser == mlp_pkg::ACT_W1) &&
                    (int'(in_src) <= MAX_INPUTS) && (int'(in_tgt) <= MAX_HIDDEN);
  assign w2_we    = in_acc && (in_tuser == mlp_pkg::ACT_W2) &&
                    (int'(in_src) <= MAX_HIDDEN) && (int'(in_tgt) <= MAX_OUTPUTS);

  always_ff @(posedge clk) begin
    if (w1_we) begin
      w1_mem[w1_waddr] <= in_wgt;
    end
    w1_q_r <= w1_mem[w1_raddr];
  end

  always_ff @(posedge clk) begin
    if (w2_we) begin
      w2_mem[w2_waddr] <= in_wgt;
    end
    w2_q_r <= w2_mem[w2_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || acc_clr) begin
      for (int i = 0; i < MAX_HIDDEN; i++) begin
        acc_r[i] <= '0;
      end
    end else if (acc_we) begin
      acc_r[acc_widx] <= acc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (hid_we) begin
      hid_r[hid_widx] <= hid_wdata;
    end
  end

  // combinational helpers
  logic [HCW-1:0]   idx1_m1, idx2_m1, j_m1;
  logic [ACC_W-1:0] abs_sum, mag40;
  logic [23:0]      q_ext, q255, rem;
  logic [16:0]      q_fix;
  logic [15:0]      x_abs;
  logic [NIW-1:0]   pos_ext;

  assign idx1_m1 = idx1_r - 1'b1;
  assign idx2_m1 = idx2_r - 1'b1;
  assign j_m1    = j_r - 1'b1;
  assign pos_ext = NIW'(pos_r);

  always_comb begin
    state_nxt     = state_r;
    fstep_nxt     = fstep_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    oj_nxt        = oj_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    idx1_nxt      = idx1_r;
    idx2_nxt      = idx2_r;
    pix_nxt       = pix_r;
    last_nxt      = last_r;
    mism_nxt      = mism_r;
    unit_nxt      = unit_r;
    pos_nxt       = pos_r;
    b255_nxt      = b255_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    mag_nxt       = mag_r;
    q_nxt         = q_r;
    o_nxt         = o_r;
    cls_nxt       = cls_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    w1_raddr      = W1AW'(W1AW'(unit_r) * W1AW'(W1_STRIDE) + W1AW'(k_r));
    w2_raddr      = W2AW'(W2AW'(k_r) * W2AW'(W2_STRIDE) + W2AW'(oj_r));
    acc_we        = 1'b0;
    acc_clr       = 1'b0;
    acc_widx      = idx2_m1[HIW-1:0];
    acc_wdata     = acc_r[idx2_m1[HIW-1:0]] + ACC_W'(mul_p);
    hid_we        = 1'b0;
    hid_widx      = j_m1[HIW-1:0];
    mul_a         = $signed({17'd0, pix_r});
    mul_b         = mlp_pkg::MUL_B_W'(w1_q_r);
    abs_sum       = sum_r[ACC_W-1] ? ACC_W'(-sum_r) : ACC_W'(sum_r);
    mag40         = abs_sum + mlp_pkg::ROUND_HALF;
    q_ext         = {8'd0, q_r};
    q255          = (q_ext << 8) - q_ext;
    rem           = {1'b0, mag_r} - q255;
    q_fix         = (rem >= 24'd255) ? ({1'b0, q_r} + 17'd1) : {1'b0, q_r};
    if (sat_r) begin
      x_abs = neg_r ? 16'd32768 : 16'd32767;
    end else if (!neg_r && (q_fix > 17'd32767)) begin
      x_abs = 16'd32767;
    end else begin
      x_abs = q_fix[15:0];
    end
    hid_wdata     = mlp_pkg::sigmoid_q12(neg_r, x_abs);

    unique case (state_r)
      mlp_pkg::S_IDLE: begin
        if (in_acc && (in_tuser == mlp_pkg::ACT_PIX)) begin
          pix_nxt  = in_pix;
          last_nxt = in_tlast;
          unit_nxt = UW'(pos_r) + 1'b1;
          pos_nxt  = (pos_r == 11'd2047) ? pos_r : pos_r + 11'd1;
          mism_nxt = (NIW'(pos_nxt) != ni);
          k_nxt    = HCW'(1);
          j_nxt    = HCW'(1);
          fstep_nxt = mlp_pkg::F_RD;
          if ((pos_ext < ni) && (nh != '0)) begin
            state_nxt = mlp_pkg::S_MAC;
          end else if (in_tlast) begin
            if (nh != '0) begin
              state_nxt = mlp_pkg::S_FIN;
            end else begin
              state_nxt = mlp_pkg::S_OUT;
              oj_nxt    = 3'd1;
              k_nxt     = '0;
              o_nxt     = '0;
            end
          end
        end
      end

      mlp_pkg::S_MAC: begin
        // read, multiply and accumulate overlap, one hidden unit a cycle
        if (k_r <= nh) begin
          v1_nxt   = 1'b1;
          idx1_nxt = k_r;
          k_nxt    = k_r + 1'b1;
        end
        v2_nxt   = v1_r;
        idx2_nxt = idx1_r;
        mul_a    = $signed({17'd0, pix_r});
        mul_b    = mlp_pkg::MUL_B_W'(w1_q_r);
        acc_we   = v2_r;
        if ((k_r > nh) && !v1_r && !v2_r) begin
          j_nxt     = HCW'(1);
          fstep_nxt = mlp_pkg::F_RD;
          state_nxt = last_r ? mlp_pkg::S_FIN : mlp_pkg::S_IDLE;
        end
      end

      mlp_pkg::S_FIN: begin
        unique case (fstep_r)
          mlp_pkg::F_RD: begin
            // bias weights sit at source unit zero
            w1_raddr  = W1AW'(j_r);
            fstep_nxt = mlp_pkg::F_BIAS;
          end
          mlp_pkg::F_BIAS: begin
            b255_nxt  = 25'($signed({w1_q_r, 8'd0})) - 25'(w1_q_r);
            fstep_nxt = mlp_pkg::F_SUM;
          end
          mlp_pkg::F_SUM: begin
            sum_nxt   = acc_r[j_m1[HIW-1:0]] + ACC_W'(b255_r);
            fstep_nxt = mlp_pkg::F_MAG;
          end
          mlp_pkg::F_MAG: begin
            neg_nxt   = sum_r[ACC_W-1];
            sat_nxt   = (mag40 >= mlp_pkg::DIV_SAT);
            mag_nxt   = mag40[22:0];
            fstep_nxt = mlp_pkg::F_MUL;
          end
          mlp_pkg::F_MUL: begin
            mul_a     = $signed({2'd0, mag_r});
            mul_b     = mlp_pkg::RECIP_255;
            fstep_nxt = mlp_pkg::F_PROD;
          end
          mlp_pkg::F_PROD: begin
            q_nxt     = mul_p[38:23];
            fstep_nxt = mlp_pkg::F_DIV;
          end
          mlp_pkg::F_DIV: begin
            // correct the low estimate, saturate, sigmoid
            hid_we    = 1'b1;
            fstep_nxt = mlp_pkg::F_RD;
            if (j_r == nh) begin
              state_nxt = mlp_pkg::S_OUT;
              oj_nxt    = 3'd1;
              k_nxt     = '0;
              o_nxt     = '0;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
          default: fstep_nxt = mlp_pkg::F_RD;
        endcase
      end

      mlp_pkg::S_OUT: begin
        // source zero is the output bias with activation 1.0
        if (k_r <= nh) begin
          v1_nxt   = 1'b1;
          idx1_nxt = k_r;
          k_nxt    = k_r + 1'b1;
        end
        v2_nxt   = v1_r;
        idx2_nxt = idx1_r;
        if (idx1_r == '0) begin
          mul_a = 25'sd4096;
        end else begin
          mul_a = $signed({12'd0, hid_r[idx1_m1[HIW-1:0]]});
        end
        mul_b = mlp_pkg::MUL_B_W'(w2_q_r);
        if (v2_r) begin
          o_nxt = o_r + ACC_W'(mul_p);
        end
        if ((k_r > nh) && !v1_r && !v2_r) begin
          if (!o_r[ACC_W-1] && (o_r != '0)) begin
            cls_nxt   = oj_r - 3'd1;
            state_nxt = mlp_pkg::S_DONE;
          end else if (oj_r == mlp_pkg::CLS_LAST) begin
            cls_nxt   = mlp_pkg::CLS_NONE;
            state_nxt = mlp_pkg::S_DONE;
          end else begin
            oj_nxt = oj_r + 3'd1;
            k_nxt  = '0;
            o_nxt  = '0;
          end
        end
      end

      mlp_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, mism_r, cls_r};
          acc_clr       = 1'b1;
          pos_nxt       = '0;
          state_nxt     = mlp_pkg::S_IDLE;
        end
      end

      default: state_nxt = mlp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlp_pkg::S_IDLE;
      fstep_r     <= mlp_pkg::F_RD;
      k_r         <= '0;
      j_r         <= '0;
      oj_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fstep_r     <= fstep_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      oj_r        <= oj_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r     <= idx1_nxt;
    idx2_r     <= idx2_nxt;
    pix_r      <= pix_nxt;
    last_r     <= last_nxt;
    mism_r     <= mism_nxt;
    unit_r     <= unit_nxt;
    b255_r     <= b255_nxt;
    sum_r      <= sum_nxt;
    neg_r      <= neg_nxt;
    sat_r      <= sat_nxt;
    mag_r      <= mag_nxt;
    q_r        <= q_nxt;
    o_r        <= o_nxt;
    cls_r      <= cls_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- bench/mlp_image_classifier_core_test.sv -----
// ----------------------------------------------------------------------------
// mlp_image_classifier_core_test
// Self-checking bench for the perceptron classifier core: loads both weight
// tables, streams frames of pixels under several register settings, and
// compares every class word with a fixed-point prediction of the network.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_image_classifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_IN  = 1024;
  localparam int N_HID = 32;
  localparam int N_OUT = 8;
  localparam int W1_STR = N_HID + 1;
  localparam int W2_STR = N_OUT + 1;
  localparam int SETUP_SRC = 8;       // first-layer sources loaded up front
  localparam int DRAIN = 600;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic [2:0] cls;
    logic       mismatch;
  } class_word_t;

  class frame_classifier;
    int unsigned  ic, hc, oc;
    shortint      w1 [N_IN+1][N_HID+1];
    shortint      w2 [N_HID+1][N_OUT+1];
    longint       acc [N_HID];
    int unsigned  pos;
    class_word_t  expected_classes [$];
    int           errors;

    function new();
      ic = 1024; hc = 32; oc = 4; pos = 0; errors = 0;
      foreach (acc[k]) acc[k] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] val);
      if (idx == mlp_pkg::CFG_INPUT_COUNT) ic = val;
      else if (idx == mlp_pkg::CFG_HIDDEN_COUNT) hc = val[5:0];
      else if (idx == mlp_pkg::CFG_OUTPUT_COUNT) oc = val[3:0];
    endfunction

    function longint to_q12(longint a);
      longint q;
      if (a >= 0) q = (a + 127) / 255;
      else q = -((-a + 127) / 255);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
    endfunction

    function longint squash(longint x);
      longint a, y;
      a = (x < 0) ? -x : x;
      if (a >= 20480) y = 4096;
      else if (a >= 9728) y = (a >>> 5) + 3456;
      else if (a >= 4096) y = (a >>> 3) + 2560;
      else y = (a >>> 2) + 2048;
      return (x < 0) ? 4096 - y : y;
    endfunction

    function void note_word(logic [1:0] act, logic [47:0] d, logic last);
      int unsigned src, tgt, pix, nh, ni;
      shortint     w;
      longint      h [N_HID];
      longint      o;
      class_word_t r;
      src = d[10:0]; tgt = d[16:11]; w = d[32:17]; pix = d[40:33];
      nh = (hc > N_HID) ? N_HID : hc;
      ni = (ic > N_IN) ? N_IN : ic;
      if (act == mlp_pkg::ACT_W1) begin
        if (src <= N_IN && tgt <= N_HID) w1[src][tgt] = w;
      end else if (act == mlp_pkg::ACT_W2) begin
        if (src <= N_HID && tgt <= N_OUT) w2[src][tgt] = w;
      end else if (act == mlp_pkg::ACT_PIX) begin
        if (pos < ni)
          for (int j = 1; j <= nh; j++) acc[j-1] += longint'(pix) * w1[pos+1][j];
        if (pos < 2047) pos++;
        if (last) begin
          r.cls = mlp_pkg::CLS_NONE;
          for (int j = 1; j <= nh; j++)
            h[j-1] = squash(to_q12(acc[j-1] + 255 * longint'(w1[0][j])));
          for (int j = 1; j <= 4; j++) begin
            o = 4096 * longint'(w2[0][j]);
            for (int i = 1; i <= nh; i++) o += h[i-1] * w2[i][j];
            if (o > 0) begin
              r.cls = 3'(j - 1);
              break;
            end
          end
          r.mismatch = (pos != ni);
          expected_classes.push_back(r);
          foreach (acc[k]) acc[k] = 0;
          pos = 0;
        end
      end
    endfunction

    function void check_result(logic [7:0] d);
      class_word_t r;
      if (expected_classes.size() == 0) begin
        $display("%0t: unexpected class word, expected none, actual %h", $realtime, d);
        errors++;
        return;
      end
      r = expected_classes.pop_front();
      if (d[2:0] !== r.cls) begin
        $display("%0t: class_index expected %0d actual %0d", $realtime, r.cls, d[2:0]);
        errors++;
      end
      if (d[3] !== r.mismatch) begin
        $display("%0t: count_mismatch expected %0d actual %0d", $realtime, r.mismatch, d[3]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;   // weight_source, weight_target, weight_value, pixel_value
  logic [1:0]  in_tuser;   // action
  logic        in_tlast;
  logic        out_tvalid, out_tready;
  logic [7:0]  out_tdata;  // class_index, count_mismatch

  frame_classifier model = new();
  int     send_pct, recv_pct;
  bit     hold_req;
  longint cycles;
  int     words_sent;
  int unsigned cur_ic;

  mlp_image_classifier_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("mlp_image_classifier_core_test NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  int  hold_cnt = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 4000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) model.note_word(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) model.check_result(out_tdata);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic [1:0] act, input int src, input int tgt,
                           input int wv, input int pix, input bit last);
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tlast  <= last;
    in_tdata  <= {7'd0, pix[7:0], wv[15:0], tgt[5:0], src[10:0]};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  function automatic int rand_weight();
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int rand_pixel();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // a word that never reads a weight: stray write or unknown action
  task automatic noise_word();
    logic [1:0] act;
    act = 2'($urandom_range(3));
    if (act == mlp_pkg::ACT_PIX) act = mlp_pkg::ACT_NONE;
    send_word(act, $urandom_range(2047), $urandom_range(63), rand_weight(),
              $urandom_range(255), $urandom_range(1));
  endtask

  task automatic frame(input int len, input bit noisy);
    for (int k = 0; k < len; k++) begin
      if (noisy && $urandom_range(7) == 0) noise_word();
      send_word(mlp_pkg::ACT_PIX, $urandom_range(2047), $urandom_range(63),
                $urandom_range(65535), rand_pixel(), k == len - 1);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (model.expected_classes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_all(input int ic, input int hc, input int oc);
    write_reg(mlp_pkg::CFG_INPUT_COUNT, 11'(ic));
    write_reg(mlp_pkg::CFG_HIDDEN_COUNT, 11'(hc));
    write_reg(mlp_pkg::CFG_OUTPUT_COUNT, 11'(oc));
    cur_ic = ic;
  endtask

  // reads stay within sources 0..SETUP_SRC: frames are short or input_count small
  task automatic random_frames(input int budget);
    int start, ni, len;
    start = words_sent;
    ni = (cur_ic > N_IN) ? N_IN : cur_ic;
    while (words_sent - start < budget) begin
      if (ni > SETUP_SRC) len = $urandom_range(1, SETUP_SRC);
      else if ($urandom_range(9) < 6 && ni > 0) len = ni;
      else len = $urandom_range(1, ni + 3);
      if ($urandom_range(5) == 0)
        send_word($urandom_range(1) ? mlp_pkg::ACT_W1 : mlp_pkg::ACT_W2,
                  $urandom_range(SETUP_SRC), $urandom_range(1, N_HID), rand_weight(), 0, 0);
      frame(len, $urandom_range(3) == 0);
    end
  endtask

  initial begin
    int cfgs [7][3] = '{'{8, 32, 4}, '{1, 1, 8}, '{0, 0, 5}, '{2047, 63, 15},
                        '{5, 17, 4}, '{1024, 32, 6}, '{8, 32, 8}};
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = mlp_pkg::CFG_INPUT_COUNT; cfg_data = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = mlp_pkg::ACT_W1; in_tlast = 1'b0;
    out_tready = 1'b0;
    hold_req = 0; cycles = 0; words_sent = 0; cur_ic = 1024;
    send_pct = 9; recv_pct = 83;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every weight that a frame can read
    for (int s = 0; s <= SETUP_SRC; s++)
      for (int t = 1; t <= N_HID; t++)
        send_word(mlp_pkg::ACT_W1, s, t, $urandom_range(65535) >> $urandom_range(3), 0, 0);
    for (int s = 0; s <= N_HID; s++)
      for (int t = 0; t <= N_OUT; t++)
        send_word(mlp_pkg::ACT_W2, s, t, $urandom_range(65535), 0, 0);

    // directed: extremes, out-of-range writes, unknown action, frame shapes
    send_word(mlp_pkg::ACT_W1, 1, 1, 32767, 0, 0);
    send_word(mlp_pkg::ACT_W1, 2, 1, -32768, 0, 0);
    send_word(mlp_pkg::ACT_W1, 1025, 5, 1234, 0, 0);
    send_word(mlp_pkg::ACT_W1, 2047, 63, -1, 0, 0);
    send_word(mlp_pkg::ACT_W1, 3, 33, 77, 0, 0);
    send_word(mlp_pkg::ACT_W1, 3, 0, 55, 0, 0);
    send_word(mlp_pkg::ACT_W2, 33, 1, 99, 0, 0);
    send_word(mlp_pkg::ACT_W2, 5, 9, 99, 0, 0);
    send_word(mlp_pkg::ACT_W2, 0, 0, -32768, 0, 0);
    send_word(mlp_pkg::ACT_NONE, 2047, 63, 65535, 255, 1);
    send_word(mlp_pkg::ACT_PIX, 0, 0, 0, 255, 0);
    send_word(mlp_pkg::ACT_PIX, 2047, 63, 65535, 0, 1);   // short frame under reset counts
    send_word(mlp_pkg::ACT_PIX, 0, 0, 0, 255, 1);
    settle();
    set_all(5, 32, 4);
    frame(5, 0);
    frame(7, 0);                                 // extra pixels
    random_frames(40);
    settle();

    foreach (cfgs[p]) begin
      if (p == 3) begin
        send_pct = 83; recv_pct = 9;
      end else if (p == 5) begin
        send_pct = 0; recv_pct = 0;
      end
      set_all(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
      if (p == 6) hold_req = 1;
      random_frames(70);
      settle();
    end

    if (model.errors == 0 && model.expected_classes.size() == 0) begin
      $display("mlp_image_classifier_core_test OK");
    end else begin
      $display("mlp_image_classifier_core_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
